/* src/v3a_pkg.sv */
// Shared types, constants and helper functions for the three-component vector ALU.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package v3a_pkg;

  localparam int DATA_W        = 32;
  localparam int KIND_W        = 4;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int ACC_W         = PROD_W + 2;
  localparam int ROOT_W        = DATA_W;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 4'd0,
    KIND_SUB   = 4'd1,
    KIND_SCALE = 4'd2,
    KIND_CPROD = 4'd3,
    KIND_CROSS = 4'd4,
    KIND_DOT   = 4'd5,
    KIND_SQMAG = 4'd6,
    KIND_MAG   = 4'd7,
    KIND_NORM  = 4'd8,
    KIND_ADDSC = 4'd9,
    KIND_NEG   = 4'd10
  } kind_e;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic  ov;
    word_t val;
  } sat_t;

  // Per-request sideband that travels alongside the root and divider pipes.
  typedef struct packed {
    logic            valid;
    kind_e           kind;
    word_t [2:0]     a;
    word_t [2:0]     res;
    word_t           scalar;
    word_t           mag;
    logic            ov;
  } side_t;

  // Clamp to [~hi, hi]; the low bound is -hi-1.
  function automatic sat_t sat_acc(input logic signed [ACC_W-1:0] v,
                                   input logic signed [ACC_W-1:0] hi);
    sat_t r;
    r.ov = 1'b0;
    if (v > hi) begin
      r.ov  = 1'b1;
      r.val = hi[DATA_W-1:0];
    end else if (v < ~hi) begin
      r.ov  = 1'b1;
      r.val = ~hi[DATA_W-1:0];
    end else begin
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Sign-extend from the low sat_bits bits.
  function automatic logic signed [DATA_W-1:0] sext_w(input word_t u, input int sat_bits);
    logic signed [DATA_W-1:0] t;
    t = signed'(u << (DATA_W - sat_bits));
    return t >>> (DATA_W - sat_bits);
  endfunction

endpackage

`default_nettype wire

/* src/vector3_alu.sv */
// Top level of the three-component fixed-point vector ALU.
// Depends on v3a_pkg, v3a_lane, v3a_sqrt and v3a_div.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_ready_o   | kind_i, a_x/y/z_i, b_x/y/z_i, scale_i
//   out     | output    | out_valid_o / out_ready_i | res_x/y/z_o, res_scalar_o, overflow_o
//
// One request is accepted every cycle while the output is not stalled, and each yields one
// result after operand multiply, merge and saturate, 32 root stages, FRAC_BITS + 1 divider
// stages and the output register. The pipeline's length is set by the square root and the
// normalize divider, which every request passes through so that results stay in order.
// Reset clears only the valid bits of the pipeline and the output register.
// All stages advance together whenever the output register is empty or being drained;
// a stalled output freezes the whole pipeline, and in_ready_o follows that same enable.
`timescale 1ns / 1ps
`default_nettype none

module vector3_alu #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = v3a_pkg::WORD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [v3a_pkg::KIND_W-1:0]        kind_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] a_x_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] a_y_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] a_z_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] b_x_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] b_y_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] b_z_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] scale_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [v3a_pkg::DATA_W-1:0]      res_x_o,
  output logic signed [v3a_pkg::DATA_W-1:0]      res_y_o,
  output logic signed [v3a_pkg::DATA_W-1:0]      res_z_o,
  output logic signed [v3a_pkg::DATA_W-1:0]      res_scalar_o,
  output logic                                   overflow_o
);
  import v3a_pkg::*;

  // Results clamp to the signed range of the narrower of WORD_BITS and the port width.
  localparam int SAT_BITS = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
  localparam int Q_W      = FRAC_BITS + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI =
    signed'((ACC_W'(1) << (SAT_BITS - 1)) - ACC_W'(1));

  // The whole pipeline moves as one while the output register can take a result.
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Operands are first narrowed to the saturation width, as the arithmetic assumes.
  logic signed [DATA_W-1:0] in_a [3];
  logic signed [DATA_W-1:0] in_b [3];
  logic signed [DATA_W-1:0] in_s;

  assign in_a[0] = sext_w(a_x_i, SAT_BITS);
  assign in_a[1] = sext_w(a_y_i, SAT_BITS);
  assign in_a[2] = sext_w(a_z_i, SAT_BITS);
  assign in_b[0] = sext_w(b_x_i, SAT_BITS);
  assign in_b[1] = sext_w(b_y_i, SAT_BITS);
  assign in_b[2] = sext_w(b_z_i, SAT_BITS);
  assign in_s    = sext_w(scale_i, SAT_BITS);

  // Stage 1: three multiplier lanes, one per component. Lane i sees its own operands and
  // those of the two following components, which is what the cross product needs.
  logic signed [PROD_W-1:0] p0 [3];
  logic signed [PROD_W-1:0] p1 [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3a_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .kind_i (kind_e'(kind_i)),
      .a_i    (in_a[i]),
      .b_i    (in_b[i]),
      .a_n_i  (in_a[(i + 1) % 3]),
      .b_n_i  (in_b[(i + 1) % 3]),
      .a_m_i  (in_a[(i + 2) % 3]),
      .b_m_i  (in_b[(i + 2) % 3]),
      .s_i    (in_s),
      .p0_o   (p0[i]),
      .p1_o   (p1[i])
    );
  end

  logic                     s1_valid_q;
  kind_e                    s1_kind_q;
  logic signed [DATA_W-1:0] s1_a_q [3];
  logic signed [DATA_W-1:0] s1_b_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_kind_q <= kind_e'(kind_i);
      s1_a_q    <= in_a;
      s1_b_q    <= in_b;
    end
  end

  // Stage 2: merge the lanes. Sums of products are formed exactly before the floor shift,
  // so the dot product and the cross terms round only once. Everything but magnitude and
  // normalize is final here.
  side_t                    s2_d;
  side_t                    s2_q;
  logic [PROD_W-1:0]        rad_q;
  logic signed [ACC_W-1:0]  dsum;
  logic signed [ACC_W-1:0]  ax, bx, pv0, pv1, v;
  sat_t                     st_v, st_s;
  logic                     ov_acc;

  always_comb begin
    s2_d       = '0;
    s2_d.valid = s1_valid_q;
    s2_d.kind  = s1_kind_q;
    ov_acc     = 1'b0;
    ax         = '0;
    bx         = '0;
    pv0        = '0;
    pv1        = '0;
    v          = '0;
    st_v       = '0;
    dsum       = ACC_W'(p0[0]) + ACC_W'(p0[1]) + ACC_W'(p0[2]);
    for (int i = 0; i < 3; i++) begin
      s2_d.a[i] = s1_a_q[i];
      ax        = ACC_W'(s1_a_q[i]);
      bx        = ACC_W'(s1_b_q[i]);
      pv0       = ACC_W'(p0[i]);
      pv1       = ACC_W'(p1[i]);
      case (s1_kind_q) inside
        KIND_ADD:               v = ax + bx;
        KIND_SUB:               v = ax - bx;
        KIND_SCALE, KIND_CPROD: v = pv0 >>> FRAC_BITS;
        KIND_CROSS:             v = (pv0 - pv1) >>> FRAC_BITS;
        KIND_ADDSC:             v = ax + (pv0 >>> FRAC_BITS);
        KIND_NEG:               v = -ax;
        default:                v = '0;
      endcase
      st_v        = sat_acc(v, SAT_HI);
      s2_d.res[i] = st_v.val;
      ov_acc      = ov_acc | st_v.ov;
    end
    if (s1_kind_q == KIND_DOT || s1_kind_q == KIND_SQMAG) begin
      st_s = sat_acc(dsum >>> FRAC_BITS, SAT_HI);
    end else begin
      st_s = '0;
    end
    s2_d.scalar = st_s.val;
    s2_d.ov     = ov_acc | st_s.ov;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q.valid <= 1'b0;
    end else if (en) begin
      s2_q <= s2_d;
    end
  end

  // The sum of squares is non-negative and below 2^64, so its low word is the radicand.
  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= dsum[PROD_W-1:0];
    end
  end

  // Square root of the sum of squares, with the sideband delayed to match.
  logic [ROOT_W-1:0] root;
  side_t             sq_sb_q [ROOT_W];

  v3a_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROOT_W; i++) begin
        sq_sb_q[i].valid <= 1'b0;
      end
    end else if (en) begin
      sq_sb_q[0] <= s2_q;
      for (int i = 1; i < ROOT_W; i++) begin
        sq_sb_q[i] <= sq_sb_q[i-1];
      end
    end
  end

  // Normalize: each component magnitude divided by the root, in three divider lanes.
  side_t             dv_in;
  side_t             dv_sb_q [Q_W];
  logic [Q_W-1:0]    quo [3];

  always_comb begin
    dv_in     = sq_sb_q[ROOT_W-1];
    dv_in.mag = root;
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    word_t a_abs;
    assign a_abs = dv_in.a[i][DATA_W-1] ? -dv_in.a[i] : dv_in.a[i];

    v3a_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (a_abs),
      .den_i (root),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Q_W; i++) begin
        dv_sb_q[i].valid <= 1'b0;
      end
    end else if (en) begin
      dv_sb_q[0] <= dv_in;
      for (int i = 1; i < Q_W; i++) begin
        dv_sb_q[i] <= dv_sb_q[i-1];
      end
    end
  end

  // Final merge: fill in magnitude and normalize. A zero vector passes through unchanged.
  side_t                   fin;
  word_t                   res_f [3];
  word_t                   scal_f;
  logic                    ov_f;
  logic signed [ACC_W-1:0] qv;
  sat_t                    st_q;
  sat_t                    st_m;

  assign fin = dv_sb_q[Q_W-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_f[i] = fin.res[i];
    end
    scal_f = fin.scalar;
    ov_f   = fin.ov;
    qv     = '0;
    st_q   = '0;
    st_m   = sat_acc(signed'(ACC_W'(fin.mag)), SAT_HI);
    if (fin.kind == KIND_MAG) begin
      scal_f = st_m.val;
      ov_f   = st_m.ov;
    end
    if (fin.kind == KIND_NORM) begin
      if (fin.mag == '0) begin
        for (int i = 0; i < 3; i++) begin
          res_f[i] = fin.a[i];
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          qv       = signed'(ACC_W'(quo[i]));
          qv       = fin.a[i][DATA_W-1] ? -qv : qv;
          st_q     = sat_acc(qv, SAT_HI);
          res_f[i] = st_q.val;
          ov_f     = ov_f | st_q.ov;
        end
      end
    end
  end

  // Output register.
  word_t res_x_q, res_y_q, res_z_q, res_s_q;
  logic  ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_x_q <= res_f[0];
      res_y_q <= res_f[1];
      res_z_q <= res_f[2];
      res_s_q <= scal_f;
      ov_q    <= ov_f;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign res_x_o      = signed'(res_x_q);
  assign res_y_o      = signed'(res_y_q);
  assign res_z_o      = signed'(res_z_q);
  assign res_scalar_o = signed'(res_s_q);
  assign overflow_o   = ov_q;

`ifndef NO_ASSERTIONS
  // A scalar result never comes with a vector result.
  a_scalar_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (res_scalar_o != '0) |->
      (res_x_o == '0) && (res_y_o == '0) && (res_z_o == '0))
    else $error("scalar and vector results both nonzero");

  // A raised flag means some field sits on a saturation bound.
  a_ov_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |->
      (res_x_o == SAT_HI[DATA_W-1:0]) || (res_x_o == ~SAT_HI[DATA_W-1:0]) ||
      (res_y_o == SAT_HI[DATA_W-1:0]) || (res_y_o == ~SAT_HI[DATA_W-1:0]) ||
      (res_z_o == SAT_HI[DATA_W-1:0]) || (res_z_o == ~SAT_HI[DATA_W-1:0]) ||
      (res_scalar_o == SAT_HI[DATA_W-1:0]) || (res_scalar_o == ~SAT_HI[DATA_W-1:0]))
    else $error("overflow flagged without a saturated field");

  // Each component is at most the magnitude, so a normalized component is at most one.
  a_norm_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.valid && (fin.kind == KIND_NORM) && (fin.mag != '0) |->
      (quo[0] <= (Q_W'(1) << FRAC_BITS)) && (quo[1] <= (Q_W'(1) << FRAC_BITS)) &&
      (quo[2] <= (Q_W'(1) << FRAC_BITS)))
    else $error("normalize quotient above one");
`endif

endmodule

`default_nettype wire

/* src/v3a_lane.sv */
// One multiplier lane of the vector ALU: picks operands by operation, registers two products.
// Depends on v3a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module v3a_lane (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire v3a_pkg::kind_e                   kind_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] a_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] b_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] a_n_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] b_n_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] a_m_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] b_m_i,
  input  wire logic signed [v3a_pkg::DATA_W-1:0] s_i,
  output logic signed [v3a_pkg::PROD_W-1:0]      p0_o,
  output logic signed [v3a_pkg::PROD_W-1:0]      p1_o
);
  import v3a_pkg::*;

  logic signed [DATA_W-1:0] op0_x, op0_y;
  logic signed [PROD_W-1:0] p0_q, p1_q;

  always_comb begin
    op0_x = '0;
    op0_y = '0;
    case (kind_i) inside
      KIND_SCALE: begin
        op0_x = a_i;
        op0_y = s_i;
      end
      KIND_CPROD, KIND_DOT: begin
        op0_x = a_i;
        op0_y = b_i;
      end
      KIND_SQMAG, KIND_MAG, KIND_NORM: begin
        op0_x = a_i;
        op0_y = a_i;
      end
      KIND_ADDSC: begin
        op0_x = b_i;
        op0_y = s_i;
      end
      KIND_CROSS: begin
        op0_x = a_n_i;
        op0_y = b_m_i;
      end
      default: ;
    endcase
  end

  // The second product is only the subtracted term of the cross product.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= op0_x * op0_y;
      p1_q <= a_m_i * b_n_i;
    end
  end

  assign p0_o = p0_q;
  assign p1_o = p1_q;

endmodule

`default_nettype wire

/* src/v3a_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
// Depends on v3a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module v3a_sqrt #(
  parameter int ROOT_W = v3a_pkg::ROOT_W
) (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic [2*ROOT_W-1:0]   rad_i,
  output logic [ROOT_W-1:0]          root_o
);
  import v3a_pkg::*;

  localparam int IN_W = 2 * ROOT_W;

  logic [ROOT_W+1:0] rem_q  [ROOT_W-1];
  logic [IN_W-1:0]   rad_q  [ROOT_W-1];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_step
    logic [ROOT_W+1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [IN_W-1:0]   rad_in;
    logic [ROOT_W+3:0] cand;
    logic [ROOT_W+3:0] trial;
    logic              ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
    end

    assign cand  = {rem_in, rad_in[IN_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (cand >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[s] <= {root_in[ROOT_W-2:0], ge};
      end
    end

    if (s < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[s] <= rad_in << 2;
          rem_q[s] <= ge ? (ROOT_W+2)'(cand - trial) : cand[ROOT_W+1:0];
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

`default_nettype wire

/* src/v3a_div.sv */
// Pipelined restoring divider for normalize: (mag << FRAC_BITS) / den, one quotient bit per stage.
// The quotient never exceeds 2^FRAC_BITS because den is at least mag. Depends on v3a_pkg.
`timescale 1ns / 1ps
`default_nettype none

module v3a_div #(
  parameter int FRAC_BITS = v3a_pkg::FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [v3a_pkg::DATA_W-1:0]  mag_i,
  input  wire logic [v3a_pkg::DATA_W-1:0]  den_i,
  output logic [FRAC_BITS:0]               quo_o
);
  import v3a_pkg::*;

  localparam int Q_W = FRAC_BITS + 1;

  logic [DATA_W-1:0] rem_q [Q_W-1];
  logic [DATA_W-1:0] den_q [Q_W-1];
  logic [Q_W-1:0]    quo_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_step
    logic [DATA_W-1:0] rem_in;
    logic [DATA_W-1:0] den_in;
    logic [Q_W-1:0]    quo_in;
    logic              bit_in;
    logic [DATA_W:0]   cand;
    logic              ge;

    // The dividend is mag followed by zeros, so only the first stage brings in a live bit.
    if (s == 0) begin : g_first
      assign rem_in = mag_i >> 1;
      assign den_in = den_i;
      assign quo_in = '0;
      assign bit_in = mag_i[0];
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign bit_in = 1'b0;
    end

    assign cand = {rem_in, bit_in};
    assign ge   = (cand >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s] <= {quo_in[Q_W-2:0], ge};
      end
    end

    if (s < Q_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? DATA_W'(cand - {1'b0, den_in}) : cand[DATA_W-1:0];
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[Q_W-1];

endmodule

`default_nettype wire

/* test/vector3_alu_checker.sv */
// Result checker for the three-component vector ALU: watches both channels, predicts each
// accepted request with its own fixed-point model and compares results in order.
// Depends on v3a_pkg for the operation codes.
`timescale 1ns / 1ps

module vector3_alu_checker
  import v3a_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [KIND_W-1:0]  kind_i,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] scale_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] res_x_i,
  input  logic signed [31:0] res_y_i,
  input  logic signed [31:0] res_z_i,
  input  logic signed [31:0] res_scalar_i,
  input  logic               overflow_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] scalar;
    logic               ov;
  } alu_result_t;

  alu_result_t expected_results[$];
  int          mismatch_count;

  function automatic logic signed [31:0] clamp_q16(input wide_t v, inout logic ov);
    if (v > wide_t'(2147483647)) begin
      ov = 1'b1;
      return 32'sh7fffffff;
    end else if (v < -wide_t'(2147483647) - wide_t'(1)) begin
      ov = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic alu_result_t predict_vector_op(
      input logic [3:0] kind, input logic signed [31:0] ax, ay, az, bx, by, bz, s);
    wide_t        a[3];
    wide_t        b[3];
    wide_t        sv;
    wide_t        q;
    logic signed [31:0] res[3];
    logic signed [31:0] sc;
    logic [63:0]  m;
    logic         ov;
    alu_result_t  r;
    a[0] = ax; a[1] = ay; a[2] = az;
    b[0] = bx; b[1] = by; b[2] = bz;
    sv = s;
    res[0] = 0; res[1] = 0; res[2] = 0;
    sc = 0;
    ov = 1'b0;
    m = 0;
    case (kind)
      KIND_ADD:   for (int i = 0; i < 3; i++) res[i] = clamp_q16(a[i] + b[i], ov);
      KIND_SUB:   for (int i = 0; i < 3; i++) res[i] = clamp_q16(a[i] - b[i], ov);
      KIND_SCALE: for (int i = 0; i < 3; i++) res[i] = clamp_q16((a[i] * sv) >>> 16, ov);
      KIND_CPROD: for (int i = 0; i < 3; i++) res[i] = clamp_q16((a[i] * b[i]) >>> 16, ov);
      KIND_CROSS: begin
        res[0] = clamp_q16((a[1] * b[2] - a[2] * b[1]) >>> 16, ov);
        res[1] = clamp_q16((a[2] * b[0] - a[0] * b[2]) >>> 16, ov);
        res[2] = clamp_q16((a[0] * b[1] - a[1] * b[0]) >>> 16, ov);
      end
      KIND_DOT:   sc = clamp_q16((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 16, ov);
      KIND_SQMAG: sc = clamp_q16((a[0] * a[0] + a[1] * a[1] + a[2] * a[2]) >>> 16, ov);
      KIND_MAG, KIND_NORM: begin
        q = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        m = int_sqrt(q[63:0]);
        if (kind == KIND_MAG) begin
          sc = clamp_q16($signed({64'd0, m}), ov);
        end else if (m == 0) begin
          // A zero vector passes through untouched.
          for (int i = 0; i < 3; i++) res[i] = a[i][31:0];
        end else begin
          for (int i = 0; i < 3; i++) begin
            q = ((a[i] < 0 ? -a[i] : a[i]) <<< 16) / $signed({64'd0, m});
            res[i] = clamp_q16(a[i] < 0 ? -q : q, ov);
          end
        end
      end
      KIND_ADDSC: for (int i = 0; i < 3; i++)
        res[i] = clamp_q16(a[i] + ((b[i] * sv) >>> 16), ov);
      KIND_NEG:   for (int i = 0; i < 3; i++) res[i] = clamp_q16(-a[i], ov);
      default: ;
    endcase
    r.x = res[0]; r.y = res[1]; r.z = res[2];
    r.scalar = sc;
    r.ov = ov;
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    mismatch_count = 0;
  end

  assign pending_o = expected_results.size();

  always @(posedge clk_i) begin
    alu_result_t exp_r;
    if (rst_ni && in_valid_i && in_ready_i)
      expected_results.push_back(predict_vector_op(kind_i, a_x_i, a_y_i, a_z_i,
                                                   b_x_i, b_y_i, b_z_i, scale_i));
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (expected_results.size() == 0) begin
        fail_count_o <= fail_count_o + 1;
        $display("ERROR: result with no pending request at %0t", $time);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.x !== res_x_i || exp_r.y !== res_y_i || exp_r.z !== res_z_i ||
            exp_r.scalar !== res_scalar_i || exp_r.ov !== overflow_i) begin
          fail_count_o <= fail_count_o + 1;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"MISMATCH at %0t: exp x=%h y=%h z=%h s=%h ov=%b, ",
                      "got x=%h y=%h z=%h s=%h ov=%b"},
                     $time, exp_r.x, exp_r.y, exp_r.z, exp_r.scalar, exp_r.ov,
                     res_x_i, res_y_i, res_z_i, res_scalar_i, overflow_i);
        end
      end
    end
  end

endmodule

/* test/vector3_alu_tb.sv */
// Top of the vector ALU testbench: clock, reset, request stimulus and the final verdict.
// Depends on v3a_pkg, vector3_alu and vector3_alu_checker.
`timescale 1ns / 1ps

module vector3_alu_tb;
  import v3a_pkg::*;

  localparam int LATENCY = FRAC_BITS_DEF + 36;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KIND_W-1:0]  kind = '0;
  logic signed [31:0] a_x = 0, a_y = 0, a_z = 0;
  logic signed [31:0] b_x = 0, b_y = 0, b_z = 0;
  logic signed [31:0] scale = 0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] res_x, res_y, res_z, res_scalar;
  logic               overflow;
  int                 fail_count;
  int                 pending;

  // When set, the sender and the receiver respectively run without idle cycles.
  bit                 send_burst;
  bit                 recv_burst;

  vector3_alu i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .kind_i(kind), .a_x_i(a_x), .a_y_i(a_y), .a_z_i(a_z),
    .b_x_i(b_x), .b_y_i(b_y), .b_z_i(b_z), .scale_i(scale),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .res_x_o(res_x), .res_y_o(res_y), .res_z_o(res_z),
    .res_scalar_o(res_scalar), .overflow_o(overflow)
  );

  vector3_alu_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .kind_i(kind), .a_x_i(a_x), .a_y_i(a_y), .a_z_i(a_z),
    .b_x_i(b_x), .b_y_i(b_y), .b_z_i(b_z), .scale_i(scale),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .res_x_i(res_x), .res_y_i(res_y), .res_z_i(res_z),
    .res_scalar_i(res_scalar), .overflow_i(overflow),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // This bound lies far beyond the slowest legal run, so it only trips when the
  // handshake hangs.
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: before each result it waits a random number of cycles, then holds
  // ready high until a result is taken.
  initial begin
    int n;
    wait (rst_n);
    forever begin
      n = recv_burst ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Operand mix: small Q16.16 values keep most results in range, while full-range
  // and boundary values drive the saturation paths.
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3, 4: return $urandom;
      5: return $signed($urandom_range(0, 32'h0001ffff)) - 32'sh00010000;
      default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
    endcase
  endfunction

  // Sends one request. Valid is only dropped when an idle gap is drawn, so it never
  // falls and rises in the same time step between back-to-back requests.
  task automatic send_request(input logic [3:0] k,
                              input logic signed [31:0] ax, ay, az, bx, by, bz, s);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    a_x <= ax; a_y <= ay; a_z <= az;
    b_x <= bx; b_y <= by; b_z <= bz;
    scale <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    logic [3:0] k;
    k = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
    send_request(k, pick_operand(), pick_operand(), pick_operand(),
                 pick_operand(), pick_operand(), pick_operand(), pick_operand());
  endtask

  initial begin
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: boundaries of every operation and the named corner cases.
    send_request(KIND_ADD,   MAXV, MINV, ONE, MAXV, MINV, -ONE, 0);
    send_request(KIND_SUB,   MINV, MAXV, 0, MAXV, MINV, 0, 0);
    send_request(KIND_SCALE, MAXV, MINV, ONE, 0, 0, 0, MINV);
    send_request(KIND_SCALE, ONE, -ONE, 32'sh00018000, 0, 0, 0, 32'sh00020000);
    send_request(KIND_CPROD, MAXV, MINV, -ONE, MAXV, MINV, -1, 0);
    send_request(KIND_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
    send_request(KIND_CROSS, MAXV, MINV, MAXV, MINV, MAXV, MINV, 0);
    send_request(KIND_DOT,   ONE, 2 * ONE, 3 * ONE, -ONE, ONE, -1, 0);
    send_request(KIND_DOT,   MINV, MINV, MINV, MINV, MINV, MINV, 0);
    send_request(KIND_SQMAG, MAXV, MINV, MAXV, 0, 0, 0, 0);
    send_request(KIND_SQMAG, -1, 1, 0, 0, 0, 0, 0);
    send_request(KIND_MAG,   MINV, MINV, MINV, 0, 0, 0, 0);
    send_request(KIND_MAG,   3 * ONE, 4 * ONE, 0, 0, 0, 0, 0);
    send_request(KIND_NORM,  0, 0, 0, MAXV, MINV, 1, MAXV);
    send_request(KIND_NORM,  3 * ONE, -4 * ONE, 0, 0, 0, 0, 0);
    send_request(KIND_NORM,  MINV, 0, 0, 0, 0, 0, 0);
    send_request(KIND_NORM,  1, 0, 0, 0, 0, 0, 0);
    send_request(KIND_ADDSC, MAXV, MINV, ONE, MAXV, MAXV, ONE, MAXV);
    send_request(KIND_NEG,   MINV, MAXV, 0, 0, 0, 0, 0);
    send_request(4'd11, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
    send_request(4'd15, -1, -1, -1, -1, -1, -1, -1);

    // Random requests in blocks, each block drawing its own idling style.
    for (int blk = 0; blk < 21; blk++) begin
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      if (blk == 10) begin
        // Let the pipeline drain completely before carrying on.
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      repeat (50) send_random();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
